/* hw/rtl/gbs_pkg.sv */
package gbs_pkg;

  // Field widths
  localparam int CoordW = 16;
  localparam int SideW  = CoordW + 1;
  localparam int AreaW  = 2 * SideW;
  localparam int AsumW  = AreaW + 1;
  localparam int ThrW   = 9;
  localparam int SlotW  = 6;
  localparam int ProdW  = ThrW + AsumW;

  // One pixel in Q12.4, the +1 of the side length convention
  localparam logic signed [SideW:0] PixelOne = 18'sd16;

  // Threshold after reset: 0.5 in Q1.8
  localparam logic [ThrW-1:0] ThrReset = 9'd128;

  // Box corners plus its area
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
    logic [AreaW-1:0]         area;
  } gbs_entry_t;

  // Candidate box travelling down the cell chain
  typedef struct packed {
    logic       valid;
    gbs_entry_t box;
  } gbs_probe_t;

  // Running suppression result leaving a cell
  typedef struct packed {
    logic valid;
    logic hit;
  } gbs_verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AREA,
    ST_RUN,
    ST_DONE
  } gbs_state_e;

  // Side length with the +1 pixel convention, clamped at zero
  function automatic logic [SideW-1:0] side_len(input logic signed [CoordW-1:0] lo,
                                                input logic signed [CoordW-1:0] hi);
    logic signed [SideW:0] d;
    d = (SideW+1)'(hi) - (SideW+1)'(lo) + PixelOne;
    return (d > 0) ? d[SideW-1:0] : '0;
  endfunction

endpackage

/* hw/rtl/gbs_box_if.sv */
interface gbs_box_if
  import gbs_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] box_left;
  logic signed [CoordW-1:0] box_top;
  logic signed [CoordW-1:0] box_right;
  logic signed [CoordW-1:0] box_bottom;
  logic                     frame_end;

  modport source (
    output valid, box_left, box_top, box_right, box_bottom, frame_end,
    input  ready
  );

  modport sink (
    input  valid, box_left, box_top, box_right, box_bottom, frame_end,
    output ready
  );
endinterface

/* hw/rtl/gbs_res_if.sv */
interface gbs_res_if
  import gbs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             keep;
  logic [SlotW-1:0] slot;
  logic             overflow;
  logic             frame_done;

  modport source (
    output valid, keep, slot, overflow, frame_done,
    input  ready
  );

  modport sink (
    input  valid, keep, slot, overflow, frame_done,
    output ready
  );
endinterface

/* hw/rtl/gbs_cell.sv */
module gbs_cell
  import gbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ThrW-1:0]  thr_i,
  input  logic             occ_i,
  input  logic             we_i,
  input  gbs_entry_t       wdata_i,
  input  gbs_probe_t       probe_i,
  input  logic             hit_i,
  output gbs_probe_t       probe_o,
  output gbs_verdict_t     verdict_o
);

  // Kept box held by this cell
  gbs_entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      entry_q <= wdata_i;
    end
  end

  // Hand the candidate on to the next cell
  logic       fwd_v_q;
  gbs_entry_t fwd_box_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else begin
      fwd_v_q <= probe_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_box_q <= probe_i.box;
  end

  assign probe_o.valid = fwd_v_q;
  assign probe_o.box   = fwd_box_q;

  // Stage 1: intersection sides and area sum
  logic signed [CoordW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic [SideW-1:0]         iw_d, ih_d;
  logic [AsumW-1:0]         asum_d;

  always_comb begin
    x_lo   = (probe_i.box.left   > entry_q.left)   ? probe_i.box.left   : entry_q.left;
    x_hi   = (probe_i.box.right  < entry_q.right)  ? probe_i.box.right  : entry_q.right;
    y_lo   = (probe_i.box.top    > entry_q.top)    ? probe_i.box.top    : entry_q.top;
    y_hi   = (probe_i.box.bottom < entry_q.bottom) ? probe_i.box.bottom : entry_q.bottom;
    iw_d   = side_len(x_lo, x_hi);
    ih_d   = side_len(y_lo, y_hi);
    asum_d = AsumW'(probe_i.box.area) + AsumW'(entry_q.area);
  end

  logic             s1_v_q, s2_v_q, s3_v_q;
  logic             s1_occ_q, s2_occ_q, s3_occ_q;
  logic [SideW-1:0] s1_iw_q, s1_ih_q;
  logic [AsumW-1:0] s1_asum_q, s2_asum_q;
  logic [AreaW-1:0] s2_inter_q, s3_inter_q;
  logic [AsumW-1:0] s3_uni_q;
  gbs_verdict_t     verdict_q;
  logic             hit_d;

  // Stage 4 compare: inter * 256 >= thr * union, folded into the running hit
  assign hit_d = hit_i | (s3_occ_q &&
                 (ProdW'({s3_inter_q, 8'd0}) >= ProdW'(thr_i) * ProdW'(s3_uni_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      verdict_q <= '0;
    end else begin
      s1_v_q          <= probe_i.valid;
      s2_v_q          <= s1_v_q;
      s3_v_q          <= s2_v_q;
      verdict_q.valid <= s3_v_q;
      verdict_q.hit   <= hit_d;
    end
  end

  // Datapath stages
  always_ff @(posedge clk_i) begin
    s1_occ_q   <= occ_i;
    s1_iw_q    <= iw_d;
    s1_ih_q    <= ih_d;
    s1_asum_q  <= asum_d;
    s2_occ_q   <= s1_occ_q;
    s2_inter_q <= AreaW'(s1_iw_q) * AreaW'(s1_ih_q);
    s2_asum_q  <= s1_asum_q;
    s3_occ_q   <= s2_occ_q;
    s3_inter_q <= s2_inter_q;
    s3_uni_q   <= s2_asum_q - AsumW'(s2_inter_q);
  end

  assign verdict_o = verdict_q;

endmodule

/* hw/rtl/greedy_box_suppression_top.sv */
// Channel   Dir  Handshake     Payload
// box_i     in   valid/ready   box_left, box_top, box_right, box_bottom, frame_end
// res_o     out  valid/ready   keep, slot, overflow, frame_done
// cfg       in   cfg_we_i      cfg_wdata_i = overlap_threshold
//
// One item at a time: box_i.ready returns only after the candidate has walked the
// MAX_KEPT cells one per cycle, passed the four compare stages of the last cell and
// the result has been committed.
// Reset clears the kept count, sets the threshold to 0.5 and empties the output.
// A result that is not taken holds back the next item's commit, not its accept.
module greedy_box_suppression_top
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  gbs_box_if.sink         box_i,
  gbs_res_if.source       res_o
);

  localparam int CntW = $clog2(MAX_KEPT + 1);

  gbs_state_e       state_q, state_d;
  logic [ThrW-1:0]  thr_q;
  logic [CntW-1:0]  count_q, count_d;
  gbs_entry_t       in_box_q;
  logic             in_fe_q;
  logic             launch_q;
  logic             hit_q;
  logic             accept, commit, store;
  logic             out_v_q;
  logic             out_keep_q, out_ovf_q, out_fd_q;
  logic [SlotW-1:0] out_slot_q;

  gbs_probe_t       probe [MAX_KEPT+1];
  gbs_verdict_t     verdict [MAX_KEPT];
  logic [MAX_KEPT:0] hit_chain;
  logic [MAX_KEPT-1:0] cell_we;
  logic [MAX_KEPT-1:0] cell_occ;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (box_i.valid) state_d = ST_AREA;
      ST_AREA: state_d = ST_RUN;
      ST_RUN:  if (verdict[MAX_KEPT-1].valid) state_d = ST_DONE;
      ST_DONE: if (!out_v_q || res_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    box_i.ready = 1'b0;
    commit      = 1'b0;
    unique case (state_q)
      ST_IDLE: box_i.ready = 1'b1;
      ST_DONE: commit = !out_v_q || res_o.ready;
      default: ;
    endcase
  end

  assign accept = box_i.valid && box_i.ready;
  assign store  = !hit_q && (count_q < CntW'(MAX_KEPT));

  always_comb begin
    count_d = count_q;
    if (commit) begin
      if (in_fe_q) begin
        count_d = '0;
      end else if (store) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      thr_q    <= ThrReset;
      count_q  <= '0;
      launch_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      launch_q <= (state_q == ST_AREA);
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (commit) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Item capture, area, final verdict and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_box_q.left   <= box_i.box_left;
      in_box_q.top    <= box_i.box_top;
      in_box_q.right  <= box_i.box_right;
      in_box_q.bottom <= box_i.box_bottom;
      in_fe_q         <= box_i.frame_end;
    end
    if (state_q == ST_AREA) begin
      in_box_q.area <= AreaW'(side_len(in_box_q.left, in_box_q.right)) *
                       AreaW'(side_len(in_box_q.top, in_box_q.bottom));
    end
    if (state_q == ST_RUN && verdict[MAX_KEPT-1].valid) begin
      hit_q <= verdict[MAX_KEPT-1].hit;
    end
    if (commit) begin
      out_keep_q <= !hit_q;
      out_slot_q <= store ? SlotW'(count_q) : '0;
      out_ovf_q  <= !hit_q && !store;
      out_fd_q   <= in_fe_q;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.keep       = out_keep_q;
  assign res_o.slot       = out_slot_q;
  assign res_o.overflow   = out_ovf_q;
  assign res_o.frame_done = out_fd_q;

  // Cell chain
  assign probe[0].valid = launch_q;
  assign probe[0].box   = in_box_q;
  assign hit_chain[0]   = 1'b0;

  for (genvar k = 0; k < MAX_KEPT; k++) begin : g_cell
    assign cell_occ[k] = CntW'(k) < count_q;
    assign cell_we[k]  = commit && store && (count_q == CntW'(k));
    assign hit_chain[k+1] = verdict[k].hit;

    gbs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .thr_i     (thr_q),
      .occ_i     (cell_occ[k]),
      .we_i      (cell_we[k]),
      .wdata_i   (in_box_q),
      .probe_i   (probe[k]),
      .hit_i     (hit_chain[k]),
      .probe_o   (probe[k+1]),
      .verdict_o (verdict[k])
    );
  end

`ifndef ASSERT_OFF
  // The verdict of the last cell only appears while an item is being checked
  a_verdict_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    verdict[MAX_KEPT-1].valid |-> state_q == ST_RUN)
    else $error("last cell verdict outside of run");

  // The candidate leaves the chain while the item is still running
  a_probe_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probe[MAX_KEPT].valid |-> state_q == ST_RUN)
    else $error("candidate left chain outside of run");

  // Kept count never exceeds the store
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_KEPT))
    else $error("kept count beyond store size");

  // At most one cell is written, and only for a kept box
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cell_we) && ((cell_we == '0) || !hit_q))
    else $error("bad store write");
`endif

endmodule

/* verif/greedy_box_suppression_checker.sv */
`timescale 1ns / 1ps

// Watches the box and result channels, predicts the keep/suppress verdict of
// every accepted box and compares it with the results the block hands out.
module greedy_box_suppression_checker
  import gbs_pkg::*;
#(
  parameter int KeptDepth = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [ThrW-1:0] cfg_wdata_i,
  gbs_box_if              box_i,
  gbs_res_if              res_i,
  output int              mismatches_o,
  output int              pending_o,
  output int              kept_o,
  output int              dropped_o,
  output int              spilled_o
);

  typedef struct packed {
    logic             keep;
    logic [SlotW-1:0] slot;
    logic             overflow;
    logic             frame_done;
  } verdict_t;

  // Predictor state: boxes kept in the current frame and the IoU threshold
  gbs_entry_t      survivors [KeptDepth];
  int unsigned     survivor_cnt;
  logic [ThrW-1:0] iou_thr;
  verdict_t        verdict_q [$];

  // Side length with the one pixel (16 in Q12.4) added, never below zero
  function automatic longint unsigned span(input int lo, input int hi);
    longint d;
    d = longint'(hi) - longint'(lo) + 16;
    return (d > 0) ? longint'(d) : 64'd0;
  endfunction

  // Greedy suppression of one box against the kept boxes of this frame
  function automatic verdict_t suppress_box(input logic signed [CoordW-1:0] l,
                                            input logic signed [CoordW-1:0] t,
                                            input logic signed [CoordW-1:0] r,
                                            input logic signed [CoordW-1:0] b,
                                            input logic fe);
    verdict_t          v;
    longint unsigned   area, iw, ih, inter, uni;
    logic              hit;
    int unsigned       k;
    v    = '0;
    hit  = 1'b0;
    area = span(l, r) * span(t, b);
    for (k = 0; k < survivor_cnt && !hit; k++) begin
      iw = span((l > survivors[k].left) ? l : survivors[k].left,
                (r < survivors[k].right) ? r : survivors[k].right);
      ih = span((t > survivors[k].top) ? t : survivors[k].top,
                (b < survivors[k].bottom) ? b : survivors[k].bottom);
      inter = iw * ih;
      uni   = area + longint'(survivors[k].area) - inter;
      // no division: inter/union >= thr/256
      if (inter * 256 >= longint'(iou_thr) * uni) hit = 1'b1;
    end
    if (!hit) begin
      v.keep = 1'b1;
      if (survivor_cnt < KeptDepth) begin
        survivors[survivor_cnt] = '{left: l, top: t, right: r, bottom: b,
                                    area: area[AreaW-1:0]};
        v.slot = survivor_cnt[SlotW-1:0];
        survivor_cnt++;
      end else begin
        // store full: still kept, but later boxes never see it
        v.overflow = 1'b1;
      end
    end
    if (fe) survivor_cnt = 0;
    v.frame_done = fe;
    return v;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches_o++;
      if (mismatches_o <= 40)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t seen, want;
    if (!rst_ni) begin
      survivor_cnt = 0;
      iou_thr      = ThrReset;
      verdict_q.delete();
      mismatches_o = 0;
      kept_o       = 0;
      dropped_o    = 0;
      spilled_o    = 0;
    end else begin
      // results first: they always belong to older boxes
      if (res_i.valid && res_i.ready) begin
        seen = '{keep: res_i.keep, slot: res_i.slot, overflow: res_i.overflow,
                 frame_done: res_i.frame_done};
        if (verdict_q.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 40)
            $display("%0t: result with no box pending, expected none, got %p",
                     $time, seen);
        end else begin
          want = verdict_q.pop_front();
          check_field("keep", want.keep, seen.keep);
          check_field("slot", want.slot, seen.slot);
          check_field("overflow", want.overflow, seen.overflow);
          check_field("frame_done", want.frame_done, seen.frame_done);
        end
      end
      if (box_i.valid && box_i.ready) begin
        want = suppress_box(box_i.box_left, box_i.box_top, box_i.box_right,
                            box_i.box_bottom, box_i.frame_end);
        verdict_q = {verdict_q, want};
        if (!want.keep) dropped_o++;
        else if (want.overflow) spilled_o++;
        else kept_o++;
      end
      if (cfg_we_i) iou_thr = cfg_wdata_i;
    end
    pending_o = verdict_q.size();
  end

endmodule

/* verif/greedy_box_suppression_top_tb.sv */
`timescale 1ns / 1ps

module greedy_box_suppression_top_tb;
  import gbs_pkg::*;

  localparam int KeptMax   = 64;
  localparam int IdleLimit = 3000;
  localparam int PhaseLen  = 190;

  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
  } box_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [ThrW-1:0] cfg_wdata;

  gbs_box_if box_if ();
  gbs_res_if res_if ();

  int  mismatches, pending, kept, dropped, spilled;
  int  box_count, frame_count, idle_cycles;
  bit  src_burst;

  greedy_box_suppression_top #(
    .MAX_KEPT (KeptMax)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .box_i       (box_if),
    .res_o       (res_if)
  );

  greedy_box_suppression_checker #(
    .KeptDepth (KeptMax)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .box_i        (box_if),
    .res_i        (res_if),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .kept_o       (kept),
    .dropped_o    (dropped),
    .spilled_o    (spilled)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: too long without any accepted item means the block hung
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (box_if.valid && box_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no item accepted for %0d cycles", $time, IdleLimit);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each item, with bursts of none
  initial begin
    int stall;
    bit snk_burst;
    snk_burst = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  function automatic logic signed [CoordW-1:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[CoordW-1:0];
  endfunction

  function automatic box_t mk_box(input int l, input int t, input int r, input int b);
    return '{left: clamp16(l), top: clamp16(t), right: clamp16(r), bottom: clamp16(b)};
  endfunction

  // Box around an anchor; size and offset vary so the overlap spans the thresholds
  function automatic box_t near_box(input int cx, input int cy);
    int   w, h, x, y;
    box_t bx;
    w  = $urandom_range(0, 2400);
    h  = $urandom_range(0, 2400);
    x  = cx - w / 2 + int'($urandom_range(0, 600)) - 300;
    y  = cy - h / 2 + int'($urandom_range(0, 600)) - 300;
    bx = mk_box(x, y, x + w, y + h);
    if ($urandom_range(0, 19) == 0) bx.right = clamp16(x - int'($urandom_range(1, 400)));
    if ($urandom_range(0, 19) == 0) bx.bottom = clamp16(y - int'($urandom_range(1, 400)));
    return bx;
  endfunction

  task automatic send_box(input box_t bx, input logic fe);
    int gap;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      box_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    box_if.valid      <= 1'b1;
    box_if.box_left   <= bx.left;
    box_if.box_top    <= bx.top;
    box_if.box_right  <= bx.right;
    box_if.box_bottom <= bx.bottom;
    box_if.frame_end  <= fe;
    do @(posedge clk_i); while (!(box_if.valid && box_if.ready));
    box_count++;
    if (fe) frame_count++;
  endtask

  // Wait until every accepted box has its result back; sampled off the edge
  task automatic wait_drained();
    box_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic run_phase(input logic [ThrW-1:0] thr, input int budget);
    int   sent, kind, spot, goal, len, i, pick, n_anchor;
    int   cx [3];
    int   cy [3];
    bit   first;
    box_t bx;
    box_t hist [$];
    logic fe;
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= thr;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sent  = 0;
    first = (thr != 0);
    while (sent < budget) begin
      kind      = first ? 0 : $urandom_range(0, 99);
      first     = 1'b0;
      src_burst = ($urandom_range(0, 4) == 0);
      hist.delete();
      if (kind < 6 && thr != 0) begin
        // disjoint boxes on a grid: fills the store and runs past it
        spot = 0;
        goal = $urandom_range(65, 70);
        while (spot < goal) begin
          if (spot > 0 && $urandom_range(0, 6) == 0) begin
            bx = hist[$urandom_range(0, hist.size() - 1)];
          end else begin
            bx.left   = clamp16(-30000 + (spot % 9) * 6500 + int'($urandom_range(0, 1000)));
            bx.top    = clamp16(-30000 + (spot / 9) * 6500 + int'($urandom_range(0, 1000)));
            bx.right  = clamp16(int'(bx.left) + int'($urandom_range(0, 4000)));
            bx.bottom = clamp16(int'(bx.top) + int'($urandom_range(0, 4000)));
            spot++;
          end
          hist = {hist, bx};
          send_box(bx, spot == goal);
          sent++;
        end
      end else begin
        // clustered frame with duplicates and some noise
        len      = $urandom_range(1, 16);
        n_anchor = $urandom_range(1, 3);
        for (i = 0; i < n_anchor; i++) begin
          cx[i] = int'($urandom_range(0, 60000)) - 30000;
          cy[i] = int'($urandom_range(0, 60000)) - 30000;
        end
        for (i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 15 && hist.size() > 0) bx = hist[$urandom_range(0, hist.size() - 1)];
          else if (pick < 25) bx = box_t'({$urandom, $urandom});
          else begin
            pick = $urandom_range(0, n_anchor - 1);
            bx   = near_box(cx[pick], cy[pick]);
          end
          fe = (i == len - 1) || ($urandom_range(0, 39) == 0);
          hist = {hist, bx};
          send_box(bx, fe);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [ThrW-1:0] thr_plan [8];
    int              p;
    thr_plan = '{9'd0, 9'd256, 9'd511, 9'd1, 9'd255, 9'd64, 9'd384, 9'd128};
    thr_plan[7] = $urandom_range(0, 511);
    box_count   = 0;
    frame_count = 0;
    src_burst   = 1'b0;
    rst_ni            <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= ThrReset;
    box_if.valid      <= 1'b0;
    box_if.box_left   <= '0;
    box_if.box_top    <= '0;
    box_if.box_right  <= '0;
    box_if.box_bottom <= '0;
    box_if.frame_end  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed boxes at the reset threshold of one half
    send_box(mk_box(0, 0, 160, 160), 1'b0);         // first box always kept
    send_box(mk_box(0, 0, 160, 160), 1'b0);         // identical: suppressed
    send_box(mk_box(80, 0, 240, 160), 1'b0);        // partial overlap below 0.5
    send_box(mk_box(1000, 1000, 1100, 1100), 1'b0); // disjoint
    send_box(mk_box(500, 500, 400, 600), 1'b0);     // degenerate, stored
    send_box(mk_box(20000, 20000, 19000, 20100), 1'b0); // zero union vs degenerate
    send_box(mk_box(-32768, -32768, 32767, 32767), 1'b1); // whole plane, frame end
    send_box(mk_box(-32768, -32768, 32767, 32767), 1'b0); // store was cleared
    send_box(mk_box(-32768, -32768, -32768, -32768), 1'b0);
    send_box(mk_box(32767, 32767, 32767, 32767), 1'b1);
    send_box(mk_box(32767, 32767, -32768, -32768), 1'b0); // fully inverted
    send_box(mk_box(32767, -32768, -32768, 32767), 1'b0);
    send_box(mk_box(0, 0, 0, 0), 1'b1);             // single pixel
    send_box(mk_box(0, 0, 32, 0), 1'b0);
    send_box(mk_box(16, 0, 48, 0), 1'b0);           // IoU exactly 0.5: suppressed
    send_box(mk_box(17, 0, 49, 0), 1'b1);           // just under 0.5: kept
    send_box(mk_box(-32768, 32767, 32767, -32768), 1'b1);

    // Random phases, one threshold each, extremes included
    for (p = 0; p < 8; p++) run_phase(thr_plan[p], PhaseLen);

    wait_drained();
    repeat (KeptMax + 16) @(posedge clk_i);
    $display("Sent %0d boxes in %0d frames under 9 threshold settings from 0 to 511.",
             box_count, frame_count);
    $display("Verdicts: %0d kept, %0d suppressed, %0d kept with the store full.",
             kept, dropped, spilled);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/gbs_pkg.sv
hw/rtl/gbs_box_if.sv
hw/rtl/gbs_res_if.sv
hw/rtl/gbs_cell.sv
hw/rtl/greedy_box_suppression_top.sv
verif/greedy_box_suppression_checker.sv
verif/greedy_box_suppression_top_tb.sv
